### src/lsl_pkg.sv
// ----------------------------------------------------------------------------
// lsl_pkg: shared constants of the lane steering law
// Datapath width, fixed-point format, law constants and register indexes.
// ----------------------------------------------------------------------------
package lsl_pkg;

  // internal datapath width, covers every product and ratio of the law
  localparam int DW     = 64;
  localparam int STEP_W = 7;

  // steer magnitude is resolved to Q0.28 before the cube
  localparam int QB         = 28;
  localparam int FRAC_STEPS = QB + 1;

  localparam int DIV_POS   = 1000;
  localparam int DIV_NEG   = 2200;
  localparam int LEFT_DEN  = 715;
  localparam int RIGHT_DEN = 660;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD_ROW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFFSET  = 2'd2;

  localparam logic [9:0] TARGET_COL_RST    = 10'd220;
  localparam logic [8:0] LOOKAHEAD_ROW_RST = 9'd120;
  localparam logic [9:0] RIGHT_OFFSET_RST  = 10'd320;

endpackage

### src/lsl_mul.sv
// ----------------------------------------------------------------------------
// lsl_mul: bit-serial signed multiplier
// Shift-and-add over the multiplier bits, one bit per cycle, stops early.
// ----------------------------------------------------------------------------
module lsl_mul import lsl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] a_i,
  input  logic signed [DW-1:0] b_i,
  output logic                 done_o,
  output logic signed [DW-1:0] prod_o
);

  logic [DW-1:0] am_q, bm_q, acc_q;
  logic          neg_q, busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bm_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      am_q  <= a_i[DW-1] ? DW'(-a_i) : DW'(a_i);
      bm_q  <= b_i[DW-1] ? DW'(-b_i) : DW'(b_i);
      acc_q <= '0;
      neg_q <= a_i[DW-1] ^ b_i[DW-1];
    end else if (busy_q && bm_q != '0) begin
      if (bm_q[0]) begin
        acc_q <= acc_q + am_q;
      end
      am_q <= am_q << 1;
      bm_q <= bm_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

### src/lsl_div.sv
// ----------------------------------------------------------------------------
// lsl_div: restoring divider
// One quotient bit per cycle; a start remainder allows fraction quotients.
// ----------------------------------------------------------------------------
module lsl_div import lsl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DW-1:0]     rem_i,
  input  logic [DW-1:0]     num_i,
  input  logic [DW-1:0]     den_i,
  input  logic [STEP_W-1:0] steps_i,
  output logic              done_o,
  output logic [DW-1:0]     quo_o
);

  logic [DW:0]       r_q;
  logic [DW-1:0]     n_q, q_q, den_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DW:0]       rs;
  logic              ge;

  assign rs = {r_q[DW-1:0], n_q[DW-1]};
  assign ge = rs >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= {1'b0, rem_i};
      n_q   <= num_i;
      q_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      r_q <= ge ? rs - {1'b0, den_q} : rs;
      n_q <= n_q << 1;
      q_q <= {q_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

### src/lane_steering_law_top.sv
// ----------------------------------------------------------------------------
// lane_steering_law_top: steering command from lane and curve segments
// Sequencer around a shared bit-serial multiplier and restoring divider.
// ----------------------------------------------------------------------------
// One input word per frame gives segment A, segment B and two detection flags;
// one output word gives the steer command in signed Q1.F (F = STEER_FRAC_BITS)
// plus flags for curve law and crossing found. With both lanes found the block
// intersects A with B (B shifted right by right_offset), keeps the last
// crossing column when none is found and steers toward target_col; otherwise
// it applies the curve law at lookahead_row if curve_ok is set and segment A is
// neither level nor vertical, else the steer is zero. The raw steer s becomes
// 2*s^3, clamped to +-1. Work is one item at a time, paced by the shared
// multiplier (one multiplier bit per cycle, up to eight products in straight
// mode, six in curve mode, two for the cube) and the divider (one quotient bit
// per cycle: 64 bits for the crossing column, 29 for the steer fraction). The
// result sits in an output register, so a new word is accepted while it waits.
// Configuration writes are always ready and must be issued while idle.
module lane_steering_law_top import lsl_pkg::*; #(
  parameter  int COORD_WIDTH     = 12,
  parameter  int STEER_FRAC_BITS = 15,
  localparam int IN_TDATA_W      = ((8 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W     = ((STEER_FRAC_BITS + 1 + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input words
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // lanes_ok, curve_ok
  input  logic [1:0]             s_axis_tuser,
  // output words
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // steer
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // used_curve, cross_found
  output logic [1:0]             m_axis_tuser
);

  localparam int F = STEER_FRAC_BITS;
  localparam logic [DW-1:0] FULL_W = DW'(1) << F;
  localparam logic [DW-1:0] HALF_Q = DW'(1) << (QB - 1);
  localparam logic [DW-1:0] RND_F  = DW'(1) << (QB - 1 - F);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_U1   = 5'd1;
  localparam logic [4:0] S_U2   = 5'd2;
  localparam logic [4:0] S_T1   = 5'd3;
  localparam logic [4:0] S_T2   = 5'd4;
  localparam logic [4:0] S_S1   = 5'd5;
  localparam logic [4:0] S_S2   = 5'd6;
  localparam logic [4:0] S_CHK  = 5'd7;
  localparam logic [4:0] S_X1   = 5'd8;
  localparam logic [4:0] S_X2   = 5'd9;
  localparam logic [4:0] S_XDIV = 5'd10;
  localparam logic [4:0] S_XD   = 5'd11;
  localparam logic [4:0] S_P1   = 5'd12;
  localparam logic [4:0] S_P2   = 5'd13;
  localparam logic [4:0] S_P3   = 5'd14;
  localparam logic [4:0] S_C1   = 5'd15;
  localparam logic [4:0] S_C2   = 5'd16;
  localparam logic [4:0] S_C3   = 5'd17;
  localparam logic [4:0] S_ST0  = 5'd18;
  localparam logic [4:0] S_FDIV = 5'd19;
  localparam logic [4:0] S_SQ   = 5'd20;
  localparam logic [4:0] S_CU   = 5'd21;
  localparam logic [4:0] S_FIN  = 5'd22;

  function automatic logic signed [DW-1:0] sx(input logic [COORD_WIDTH-1:0] v);
    return {{(DW - COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  // configuration
  logic [9:0] target_col_q, right_offset_q;
  logic [8:0] lookahead_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_col_q    <= TARGET_COL_RST;
      lookahead_row_q <= LOOKAHEAD_ROW_RST;
      right_offset_q  <= RIGHT_OFFSET_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_TARGET_COL:    target_col_q    <= cfg_data_i;
        REG_LOOKAHEAD_ROW: lookahead_row_q <= cfg_data_i[8:0];
        REG_RIGHT_OFFSET:  right_offset_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // unpack the input word
  logic signed [DW-1:0] ax1, ay1, ax2, ay2, bsx, bsy, bex, bey, off_w, adx_w, ady_w;

  assign ax1   = sx(s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH]);
  assign ay1   = sx(s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH]);
  assign ax2   = sx(s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH]);
  assign ay2   = sx(s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH]);
  assign bsx   = sx(s_axis_tdata[4*COORD_WIDTH +: COORD_WIDTH]);
  assign bsy   = sx(s_axis_tdata[5*COORD_WIDTH +: COORD_WIDTH]);
  assign bex   = sx(s_axis_tdata[6*COORD_WIDTH +: COORD_WIDTH]);
  assign bey   = sx(s_axis_tdata[7*COORD_WIDTH +: COORD_WIDTH]);
  assign off_w = $signed({{(DW - 10){1'b0}}, right_offset_q});
  assign adx_w = ax2 - ax1;
  assign ady_w = ay2 - ay1;

  // sequencer state and working registers
  logic [4:0] state_q;
  logic       go_q;
  logic signed [DW-1:0] ax1_q, adx_q, ady_q, bdx_q, bdy_q, ex_q, ey_q;
  logic signed [DW-1:0] t1_q, t2_q, u_q, tn_q, sn_q, num_q, den_q, nmag_q;
  logic signed [DW-1:0] s_q, s2_q;
  logic [F:0]           mag_q;
  logic                 neg_q, lanes_q, found_q;
  logic signed [COORD_WIDTH-1:0] last_x_q;

  logic                 in_acc;
  logic                 mul_start, mul_done, div_start, div_done, use_mul;
  logic signed [DW-1:0] mul_a, mul_b, mul_prod;
  logic [DW-1:0]        div_rem, div_num, div_den, div_quo;
  logic [STEP_W-1:0]    div_steps;
  logic                 left;
  logic signed [DW-1:0] dy5, dx6, dy200, dy800, fa, fb;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // curve law factors, narrow shift-add constants
  assign left  = ady_q[DW-1];
  assign dy5   = (ady_q <<< 2) + ady_q;
  assign dx6   = (adx_q <<< 2) + (adx_q <<< 1);
  assign dy200 = (ady_q <<< 7) + (ady_q <<< 6) + (ady_q <<< 3);
  assign dy800 = dy200 <<< 2;
  assign fa    = left ? t1_q + dy200 : t1_q - dy800;
  assign fb    = left ? dy5 + dx6 : dy5 - dx6;

  // operand select for the shared multiplier
  always_comb begin
    mul_a   = adx_q;
    mul_b   = bdy_q;
    use_mul = 1'b1;
    unique case (state_q)
      S_U1:   begin mul_a = adx_q;  mul_b = bdy_q; end
      S_U2:   begin mul_a = ady_q;  mul_b = bdx_q; end
      S_T1:   begin mul_a = ey_q;   mul_b = bdx_q; end
      S_T2:   begin mul_a = ex_q;   mul_b = bdy_q; end
      S_S1:   begin mul_a = ey_q;   mul_b = adx_q; end
      S_S2:   begin mul_a = ex_q;   mul_b = ady_q; end
      S_X1:   begin mul_a = u_q;    mul_b = ax1_q; end
      S_X2:   begin mul_a = tn_q;   mul_b = adx_q; end
      S_P1:   begin mul_a = ax1_q;  mul_b = ady_q; end
      S_P2:   begin mul_a = ey_q;   mul_b = adx_q; end
      S_P3:   begin mul_a = off_w;  mul_b = ady_q; end
      S_C1:   begin mul_a = fa;     mul_b = fb;    end
      S_C2:   begin mul_a = adx_q;  mul_b = left ? -ady_q : ady_q; end
      S_C3:   begin
        mul_a = t2_q;
        mul_b = left ? DW'(LEFT_DEN) : DW'(RIGHT_DEN);
      end
      S_SQ:   begin mul_a = s_q;    mul_b = s_q;   end
      S_CU:   begin mul_a = s2_q;   mul_b = s_q;   end
      default: use_mul = 1'b0;
    endcase
  end

  assign mul_start = use_mul && !go_q;
  assign div_start = (state_q == S_XDIV || state_q == S_FDIV) && !go_q;
  assign div_rem   = (state_q == S_FDIV) ? DW'(nmag_q) : '0;
  assign div_num   = (state_q == S_FDIV) ? '0 : (t1_q[DW-1] ? DW'(-t1_q) : DW'(t1_q));
  assign div_den   = (state_q == S_FDIV) ? DW'(den_q) : DW'(u_q);
  assign div_steps = (state_q == S_FDIV) ? STEP_W'(FRAC_STEPS) : STEP_W'(DW);

  lsl_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  lsl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // crossing test on the sign-normalized terms
  logic signed [DW-1:0] un, tnn, snn, xd, nabs, prod_r, s3, mag_w;
  logic                 hit;

  assign un    = u_q[DW-1] ? -u_q : u_q;
  assign tnn   = u_q[DW-1] ? -tn_q : tn_q;
  assign snn   = u_q[DW-1] ? -sn_q : sn_q;
  assign hit   = (un != 0) && (tnn >= 0) && (tnn <= un) && (snn >= 0) && (snn <= un)
                 && !(tnn == 0 && snn == 0);
  assign xd    = $signed({{(DW - 10){1'b0}}, target_col_q}) - sx(last_x_q);
  assign nabs  = num_q[DW-1] ? -num_q : num_q;
  assign prod_r = $signed(($unsigned(mul_prod) + HALF_Q) >> QB);
  assign s3    = prod_r;
  assign mag_w = $signed((($unsigned(s3) << 1) + RND_F) >> (QB - F));

  // output register
  logic             m_valid_q, used_q, found_o_q;
  logic [F:0]       steer_q;
  logic             out_load;

  assign out_load = (state_q == S_FIN) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      go_q      <= 1'b0;
      last_x_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (mul_start || div_start) go_q <= 1'b1;
      if (mul_done || div_done)   go_q <= 1'b0;

      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: if (in_acc) begin
          if (s_axis_tuser[0]) begin
            state_q <= S_U1;
          end else if (s_axis_tuser[1] && adx_w != 0 && ady_w != 0) begin
            state_q <= S_P1;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_U1, S_U2, S_T1, S_T2, S_S1: if (mul_done) state_q <= state_q + 5'd1;
        S_S2:   if (mul_done) state_q <= S_CHK;
        S_CHK:  state_q <= hit ? S_X1 : S_XD;
        S_X1:   if (mul_done) state_q <= S_X2;
        S_X2:   if (mul_done) state_q <= S_XDIV;
        S_XDIV: if (div_done) begin
          last_x_q <= t1_q[DW-1] ? COORD_WIDTH'(-div_quo) : COORD_WIDTH'(div_quo);
          state_q  <= S_XD;
        end
        S_XD:   state_q <= S_ST0;
        S_P1:   if (mul_done) state_q <= S_P2;
        S_P2:   if (mul_done) state_q <= S_P3;
        S_P3:   if (mul_done) state_q <= (t1_q < mul_prod) ? S_ST0 : S_C1;
        S_C1:   if (mul_done) state_q <= S_C2;
        S_C2:   if (mul_done) state_q <= S_C3;
        S_C3:   if (mul_done) state_q <= S_ST0;
        S_ST0: begin
          if (nabs == 0 || nabs >= den_q) state_q <= S_FIN;
          else                            state_q <= S_FDIV;
        end
        S_FDIV: if (div_done) state_q <= S_SQ;
        S_SQ:   if (mul_done) state_q <= S_CU;
        S_CU:   if (mul_done) state_q <= S_FIN;
        S_FIN:  if (out_load) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (in_acc) begin
        lanes_q <= s_axis_tuser[0];
        found_q <= 1'b0;
        neg_q   <= 1'b0;
        mag_q   <= '0;
        ax1_q   <= ax1;
        if (s_axis_tuser[0]) begin
          adx_q <= adx_w;
          ady_q <= ady_w;
          bdx_q <= bex - bsx;
          bdy_q <= bey - bsy;
          ex_q  <= ax1 - bsx - off_w;
          ey_q  <= ay1 - bsy;
        end else begin
          // orient the curve segment so that dx is not negative
          adx_q <= adx_w[DW-1] ? -adx_w : adx_w;
          ady_q <= adx_w[DW-1] ? -ady_w : ady_w;
          ey_q  <= $signed({{(DW - 9){1'b0}}, lookahead_row_q}) - ay1;
        end
      end
      S_U1, S_T1, S_S1, S_X1, S_P1: if (mul_done) t1_q <= mul_prod;
      S_U2:  if (mul_done) u_q  <= t1_q - mul_prod;
      S_T2:  if (mul_done) tn_q <= t1_q - mul_prod;
      S_S2:  if (mul_done) sn_q <= t1_q - mul_prod;
      S_CHK: begin
        u_q  <= un;
        tn_q <= tnn;
        sn_q <= snn;
      end
      S_X2, S_P2: if (mul_done) t1_q <= t1_q + mul_prod;
      S_XDIV: if (div_done) found_q <= 1'b1;
      S_XD: begin
        num_q <= -xd;
        den_q <= (xd > 0) ? DW'(DIV_POS) : DW'(DIV_NEG);
      end
      S_P3: if (mul_done && t1_q < mul_prod) begin
        // column beyond the centre threshold: full turn
        num_q <= left ? -DW'(1) : DW'(1);
        den_q <= DW'(1);
      end
      S_C1: if (mul_done) num_q <= mul_prod;
      S_C2: if (mul_done) t2_q  <= mul_prod;
      S_C3: if (mul_done) den_q <= mul_prod;
      S_ST0: begin
        neg_q  <= num_q[DW-1];
        nmag_q <= nabs;
        if (nabs == 0)           mag_q <= '0;
        else if (nabs >= den_q)  mag_q <= (F + 1)'(FULL_W);
      end
      S_FDIV: if (div_done) s_q <= $signed((div_quo + DW'(1)) >> 1);
      S_SQ:   if (mul_done) s2_q <= prod_r;
      S_CU:   if (mul_done) begin
        mag_q <= ($unsigned(mag_w) > FULL_W) ? (F + 1)'(FULL_W) : (F + 1)'(mag_w);
      end
      S_FIN: if (out_load) begin
        if (neg_q)                            steer_q <= -mag_q;
        else if ({1'b0, mag_q} >= (F + 2)'(FULL_W)) steer_q <= (F + 1)'(FULL_W - DW'(1));
        else                                  steer_q <= mag_q;
        used_q    <= !lanes_q;
        found_o_q <= found_q;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(steer_q);
  assign m_axis_tuser  = {found_o_q, used_q};

endmodule

### src/lsl_checker.sv
// ----------------------------------------------------------------------------
// lsl_checker: port-level checks of the lane steering law
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module lsl_checker #(
  parameter int OUT_TDATA_W = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]             m_axis_tuser
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped or changed while stalled");

  // curve law never reports a crossing
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("crossing flagged in curve mode");

  // one word in flight: input closes after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is in flight");

  // with the output empty, no result shows in the cycle after an accept
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared in the cycle after accept");

endmodule

bind lane_steering_law_top lsl_checker #(
  .OUT_TDATA_W (OUT_TDATA_W)
) u_lsl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
